/* hw/rtl/ilt_pkg.sv */
// Shared types and constants for the incubator lamp thermostat.
// Holds state encodings, block-to-block structs and the fixed field widths.
// No dependencies.
package ilt_pkg;

   // Field widths
   localparam int TEMP_W   = 15;  // sample, average, limits
   localparam int STAT_W   = 16;  // peak / trough
   localparam int WEIGHT_W = 8;   // blend weight N
   localparam int CREDIT_W = 7;
   localparam int IDX_W    = 2;

   // Blend datapath widths
   localparam int ACC_W = 24;            // N*avg + sample, signed
   localparam int NUM_W = ACC_W - 1;     // magnitude of the numerator
   localparam int DVS_W = WEIGHT_W + 1;  // divisor N+1
   localparam int CNT_W = 5;

   localparam int MUL_STEPS = WEIGHT_W;  // one weight bit per cycle
   localparam int DIV_STEPS = NUM_W;     // one quotient bit per cycle

   // Register indexes
   localparam logic [IDX_W-1:0] REG_LOW_LIMIT    = 2'd0;
   localparam logic [IDX_W-1:0] REG_HIGH_LIMIT   = 2'd1;
   localparam logic [IDX_W-1:0] REG_BLEND_WEIGHT = 2'd2;

   // Register reset values
   localparam logic signed [TEMP_W-1:0] LOW_LIMIT_RST    = 15'sd3720;
   localparam logic signed [TEMP_W-1:0] HIGH_LIMIT_RST   = 15'sd3780;
   localparam logic [WEIGHT_W-1:0]      BLEND_WEIGHT_RST = 8'd9;

   // Min/max tracker reset values
   localparam logic signed [STAT_W-1:0] PEAK_RST   = 16'sh8000;
   localparam logic signed [STAT_W-1:0] TROUGH_RST = 16'sh7FFF;

   // Lamp decision constants
   localparam logic signed [STAT_W-1:0] PLAUSIBLE_TOP = 16'sd4000;
   localparam logic [CREDIT_W:0]        CREDIT_UP     = 8'd10;
   localparam logic [CREDIT_W-1:0]      CREDIT_DOWN   = 7'd4;
   localparam logic [CREDIT_W-1:0]      CREDIT_LOCK   = 7'd100;
   localparam logic [CREDIT_W-1:0]      CREDIT_MAX    = 7'd127;

   // Item kinds carried on req_tuser
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_TICK   = 1'b1;

   typedef enum logic [1:0] {
      T_IDLE,
      T_BLEND,
      T_COMMIT
   } top_state_type;

   typedef enum logic [2:0] {
      BL_IDLE,
      BL_MUL,
      BL_ABS,
      BL_DIV,
      BL_SIGN
   } blend_state_type;

   typedef struct packed {
      logic                       start;
      logic [WEIGHT_W-1:0]        weight;
      logic signed [TEMP_W-1:0]   average;
      logic signed [TEMP_W-1:0]   sample;
   } blend_req_type;

   typedef struct packed {
      logic                       done;
      logic signed [TEMP_W-1:0]   average;
   } blend_rsp_type;

   typedef struct packed {
      logic                lamp;
      logic [CREDIT_W-1:0] credit;
      logic                lockout;
   } lamp_state_type;

endpackage

/* hw/rtl/incubator_lamp_thermostat_top.sv */
// A tick, or the first sample after reset, goes straight to the commit, which loads the
// output register once it is free; a later sample first runs the bit-serial blend unit
// (8 multiply steps, one per weight bit, an abs step, 23 restoring-divide steps, a sign
// step). Throughput: one item at a time; the next item is taken as soon as the result
// sits in the output register. Reset (synchronous, active high) clears the average,
// lamp, credit, lockout and min/max trackers and loads the register defaults.
module incubator_lamp_thermostat_top
   import ilt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // Input channel
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [15:0]       req_tdata,   // [14:0] temp_sample, [15] zero
   input  logic              req_tuser,   // [0] req_type
   // Result channel
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [55:0]       rsp_tdata,   // [0] lamp_on, [1] temp_error,
                                          // [16:2] avg_temp, [32:17] peak_temp,
                                          // [48:33] trough_temp, [55:49] lamp_credit
   // Configuration port
   input  logic              csr_wr_en,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [TEMP_W-1:0] csr_wdata
);

   top_state_type st_ff, st_in;

   // Configuration registers
   logic signed [TEMP_W-1:0] low_ff, high_ff;
   logic [WEIGHT_W-1:0]      weight_ff;

   // Thermostat state
   logic signed [TEMP_W-1:0] avg_ff, avg_in;
   logic                     loaded_ff, loaded_in;
   lamp_state_type           lamp_ff, lamp_in;
   logic signed [STAT_W-1:0] peak_ff, peak_in;
   logic signed [STAT_W-1:0] trough_ff, trough_in;

   // Item in flight
   logic                     kind_ff;
   logic signed [TEMP_W-1:0] sample_ff;

   // Output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [55:0]              rsp_data_ff, rsp_data_in;

   logic                     accept;
   logic                     commit;
   logic                     blend_start;
   logic                     err;
   logic signed [STAT_W-1:0] avg_x;

   blend_req_type            breq;
   blend_rsp_type            brsp;
   lamp_state_type           lamp_nxt;

   assign accept = req_tvalid && req_tready;

   // Next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         T_IDLE: begin
            if (accept) begin
               if ((req_tuser == KIND_SAMPLE) && loaded_ff) st_in = T_BLEND;
               else st_in = T_COMMIT;
            end
         end
         T_BLEND:  if (brsp.done) st_in = T_COMMIT;
         T_COMMIT: if (commit) st_in = T_IDLE;
         default:  st_in = T_IDLE;
      endcase
   end

   // FSM outputs
   always_comb begin
      req_tready  = (st_ff == T_IDLE);
      blend_start = (st_ff == T_IDLE) && req_tvalid && (req_tuser == KIND_SAMPLE) && loaded_ff;
      commit      = (st_ff == T_COMMIT) && (!rsp_valid_ff || rsp_tready);
   end

   // Blend unit
   always_comb begin
      breq.start   = blend_start;
      breq.weight  = weight_ff;
      breq.average = avg_ff;
      breq.sample  = req_tdata[TEMP_W-1:0];
   end

   ilt_blend u_blend (
      .clock (clock),
      .reset (reset),
      .req   (breq),
      .rsp   (brsp)
   );

   // Tick decision
   ilt_lamp u_lamp (
      .cur        (lamp_ff),
      .average    (avg_ff),
      .low_limit  (low_ff),
      .high_limit (high_ff),
      .nxt        (lamp_nxt),
      .temp_error (err)
   );

   // State update at commit
   always_comb begin
      avg_in    = avg_ff;
      loaded_in = loaded_ff;
      lamp_in   = lamp_ff;
      peak_in   = peak_ff;
      trough_in = trough_ff;
      avg_x     = STAT_W'(avg_ff);
      if (commit) begin
         if (kind_ff == KIND_TICK) begin
            lamp_in = lamp_nxt;
         end else begin
            avg_in    = loaded_ff ? brsp.average : sample_ff;
            loaded_in = 1'b1;
            avg_x     = STAT_W'(avg_in);
            if (avg_x > peak_ff) peak_in = avg_x;
            else if (avg_x < trough_ff) trough_in = avg_x;
         end
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {lamp_in.credit, trough_in, peak_in, avg_in,
                         (kind_ff == KIND_TICK) && err, lamp_in.lamp};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= T_IDLE;
         low_ff       <= LOW_LIMIT_RST;
         high_ff      <= HIGH_LIMIT_RST;
         weight_ff    <= BLEND_WEIGHT_RST;
         avg_ff       <= '0;
         loaded_ff    <= 1'b0;
         lamp_ff      <= '0;
         peak_ff      <= PEAK_RST;
         trough_ff    <= TROUGH_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         avg_ff       <= avg_in;
         loaded_ff    <= loaded_in;
         lamp_ff      <= lamp_in;
         peak_ff      <= peak_in;
         trough_ff    <= trough_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               REG_LOW_LIMIT:    low_ff    <= csr_wdata;
               REG_HIGH_LIMIT:   high_ff   <= csr_wdata;
               REG_BLEND_WEIGHT: weight_ff <= csr_wdata[WEIGHT_W-1:0];
               default: ;
            endcase
         end
      end
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         kind_ff   <= req_tuser;
         sample_ff <= req_tdata[TEMP_W-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* hw/rtl/ilt_blend.sv */
// Running-average blend unit: (N*avg + sample) / (N+1), truncated toward zero.
// Bit-serial multiply over the weight bits, then restoring divide one bit a cycle.
// Depends on ilt_pkg.
module ilt_blend
   import ilt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  blend_req_type req,
   output blend_rsp_type rsp
);

   blend_state_type st_ff, st_in;

   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [WEIGHT_W-1:0]     nsr_ff, nsr_in;
   logic signed [ACC_W-1:0] mcand_ff, mcand_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [DVS_W-1:0]        dvs_ff, dvs_in;
   logic [DVS_W-1:0]        rem_ff, rem_in;
   logic [NUM_W-1:0]        num_ff, num_in;
   logic                    neg_ff, neg_in;

   logic [DVS_W:0]          trial;
   logic [DVS_W:0]          diff;
   logic                    qbit;
   logic [ACC_W-1:0]        acc_neg;
   logic [TEMP_W-1:0]       quot;

   // Next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         BL_IDLE: if (req.start) st_in = BL_MUL;
         BL_MUL:  if (cnt_ff == CNT_W'(MUL_STEPS - 1)) st_in = BL_ABS;
         BL_ABS:  st_in = BL_DIV;
         BL_DIV:  if (cnt_ff == CNT_W'(DIV_STEPS - 1)) st_in = BL_SIGN;
         BL_SIGN: st_in = BL_IDLE;
         default: st_in = BL_IDLE;
      endcase
   end

   // Divide step: shift in the next numerator bit, subtract if it fits
   assign trial   = {rem_ff, num_ff[NUM_W-1]};
   assign diff    = trial - {1'b0, dvs_ff};
   assign qbit    = (trial >= {1'b0, dvs_ff});
   assign acc_neg = -acc_ff;

   // Datapath next values
   always_comb begin
      cnt_in   = cnt_ff;
      nsr_in   = nsr_ff;
      mcand_in = mcand_ff;
      acc_in   = acc_ff;
      dvs_in   = dvs_ff;
      rem_in   = rem_ff;
      num_in   = num_ff;
      neg_in   = neg_ff;
      case (st_ff)
         BL_IDLE: begin
            if (req.start) begin
               cnt_in   = '0;
               nsr_in   = req.weight;
               mcand_in = ACC_W'(req.average);
               acc_in   = ACC_W'(req.sample);
               dvs_in   = {1'b0, req.weight} + DVS_W'(1);
            end
         end
         BL_MUL: begin
            if (nsr_ff[0]) acc_in = acc_ff + mcand_ff;
            mcand_in = mcand_ff <<< 1;
            nsr_in   = nsr_ff >> 1;
            cnt_in   = cnt_ff + CNT_W'(1);
         end
         BL_ABS: begin
            neg_in = acc_ff[ACC_W-1];
            num_in = acc_ff[ACC_W-1] ? acc_neg[NUM_W-1:0] : acc_ff[NUM_W-1:0];
            rem_in = '0;
            cnt_in = '0;
         end
         BL_DIV: begin
            rem_in = qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            num_in = {num_ff[NUM_W-2:0], qbit};
            cnt_in = cnt_ff + CNT_W'(1);
         end
         BL_SIGN: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= BL_IDLE;
      end else begin
         st_ff <= st_in;
      end
      cnt_ff   <= cnt_in;
      nsr_ff   <= nsr_in;
      mcand_ff <= mcand_in;
      acc_ff   <= acc_in;
      dvs_ff   <= dvs_in;
      rem_ff   <= rem_in;
      num_ff   <= num_in;
      neg_ff   <= neg_in;
   end

   // Result: quotient magnitude fits the sample width; restore the sign
   assign quot = num_ff[TEMP_W-1:0];

   always_comb begin
      rsp.done    = (st_ff == BL_SIGN);
      rsp.average = neg_ff ? -quot : quot;
   end

endmodule

/* hw/rtl/ilt_lamp.sv */
// Lamp decision for a tick: lockout update, lamp drive, duty credit, error flag.
// Pure combinational; the caller registers the new state.
// Depends on ilt_pkg.
module ilt_lamp
   import ilt_pkg::*;
(
   input  lamp_state_type           cur,
   input  logic signed [TEMP_W-1:0] average,
   input  logic signed [TEMP_W-1:0] low_limit,
   input  logic signed [TEMP_W-1:0] high_limit,
   output lamp_state_type           nxt,
   output logic                     temp_error
);

   logic signed [STAT_W-1:0] avg_x;
   logic signed [STAT_W-1:0] low_x;
   logic signed [STAT_W-1:0] high_x;
   logic                     lock;
   logic [CREDIT_W:0]        credit_up;

   assign avg_x  = STAT_W'(average);
   assign low_x  = STAT_W'(low_limit);
   assign high_x = STAT_W'(high_limit);

   // Lockout: set once credit reaches CREDIT_LOCK, cleared once credit drains
   always_comb begin
      lock = cur.lockout;
      if (cur.credit >= CREDIT_LOCK) lock = 1'b1;
      else if (cur.credit == '0) lock = 1'b0;
   end

   assign credit_up = {1'b0, cur.credit} + CREDIT_UP;

   always_comb begin
      nxt         = cur;
      nxt.lockout = lock;
      temp_error  = 1'b0;
      if ((avg_x > 16'sd0) && (avg_x < PLAUSIBLE_TOP) && !lock && (avg_x < low_x)) begin
         nxt.lamp   = 1'b1;
         nxt.credit = credit_up[CREDIT_W] ? CREDIT_MAX : credit_up[CREDIT_W-1:0];
      end else if (lock || (avg_x > high_x)) begin
         nxt.lamp   = 1'b0;
         nxt.credit = (cur.credit >= CREDIT_DOWN) ? (cur.credit - CREDIT_DOWN) : '0;
      end else if ((avg_x >= low_x) && (avg_x <= high_x)) begin
         // in band: hold
      end else begin
         nxt.lamp   = 1'b0;
         temp_error = 1'b1;
      end
   end

endmodule

/* hw/rtl/ilt_checker.sv */
// Port-level checks for the incubator lamp thermostat top level.
// Bound to incubator_lamp_thermostat_top; needs no package.
// Watches the result beats and the input handshake over time.
module ilt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] req_tdata,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata
);

   // A stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // A waiting input beat holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata) && $stable(req_tuser))
      else $error("input beat changed while waiting");

   // An error result never reports the lamp on
   a_err_lamp_off: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[1] && rsp_tdata[0]))
      else $error("lamp on with temperature error");

   // Credit stays at or below the lockout level plus one up step
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[55:49] <= 7'd110))
      else $error("lamp credit out of range");

   // One item at a time: no input beat right after one is taken
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while an item is in flight");

endmodule

bind incubator_lamp_thermostat_top ilt_checker u_ilt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
